>>> rtl/cat_text_stream_formatter_core_assert.svh
// Assertion macros shared by the formatter RTL.
// All checks run on i_clk and are held off while i_rst_n is low.
`ifndef CAT_TEXT_STREAM_FORMATTER_CORE_ASSERT_SVH
`define CAT_TEXT_STREAM_FORMATTER_CORE_ASSERT_SVH

// Property must hold at every clock edge.
`define CTSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// If ante holds at an edge, cons must hold at the next edge.
`define CTSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ctsf_pkg.sv
`timescale 1ns / 1ps

package ctsf_pkg;

    localparam int unsigned NumDigits = 6;
    localparam int unsigned CountW    = 4 * NumDigits;
    // worst case expansion: digits, tab, then the byte itself
    localparam int unsigned BufDepth  = NumDigits + 2;
    localparam int unsigned CntW      = $clog2(BufDepth + 1);

    typedef logic [7:0]        t_byte;
    typedef logic [CountW-1:0] t_bcd;
    typedef logic [CntW-1:0]   t_cnt;

    typedef enum logic [2:0] {
        VM_PLAIN        = 3'd0,
        VM_NUM_NONBLANK = 3'd1,
        VM_NUM_ALL      = 3'd2,
        VM_SQUEEZE      = 3'd3,
        VM_ENDS         = 3'd4,
        VM_ENDS_VIS     = 3'd5,
        VM_TABS         = 3'd6,
        VM_TABS_VIS     = 3'd7
    } t_view_mode;

    localparam t_byte ChTab    = 8'h09;
    localparam t_byte ChLf     = 8'h0A;
    localparam t_byte ChSpace  = 8'h20;
    localparam t_byte ChDollar = 8'h24;
    localparam t_byte ChDash   = 8'h2D;
    localparam t_byte ChZero   = 8'h30;
    localparam t_byte ChQuest  = 8'h3F;
    localparam t_byte ChUpperI = 8'h49;
    localparam t_byte ChUpperM = 8'h4D;
    localparam t_byte ChCaret  = 8'h5E;
    localparam t_byte ChDel    = 8'h7F;
    localparam t_byte CtrlLimit = 8'h20;
    localparam t_byte CaretOffset = 8'h40;

    localparam t_bcd BcdOne = t_bcd'(1);

endpackage

>>> rtl/ctsf_byte_if.sv
`timescale 1ns / 1ps

interface ctsf_byte_if;
    logic                valid;
    logic                ready;
    ctsf_pkg::t_byte     data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/ctsf_res_if.sv
`timescale 1ns / 1ps

interface ctsf_res_if;
    logic                valid;
    logic                ready;
    ctsf_pkg::t_byte     out_byte;
    logic                last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/cat_text_stream_formatter_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                      Word accepted when
// i_in      in   data_byte[7:0]               valid && ready
// o_out     out  out_byte[7:0], last_of_run   valid && ready
// i_cfg     in   i_cfg_data[2:0] (view_mode)  i_cfg_we
//
// An accepted byte is held in the input register, then expanded into the output
// buffer, which drains one word per cycle while o_out is ready. A byte expands
// to one word if plain, and up to NumDigits + 2 words for a numbered line start.
// Reset is synchronous, active low, and clears state to line start, counter at
// one, mode plain. A stalled o_out holds the buffer; one more input byte is
// still taken into the input register.

module cat_text_stream_formatter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctsf_byte_if.sink            i_in,
    ctsf_res_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_data
);

    ctsf_pkg::t_view_mode r_mode;
    logic                 r_line_start;
    logic                 r_blank_pend;
    ctsf_pkg::t_bcd       r_count;

    logic                 r_in_valid;
    ctsf_pkg::t_byte      r_in_byte;

    ctsf_pkg::t_byte      r_buf [ctsf_pkg::BufDepth];
    ctsf_pkg::t_cnt       r_cnt;

    logic                 w_load;
    logic                 w_take;

    ctsf_pkg::t_byte      w_num [ctsf_pkg::NumDigits + 1];
    ctsf_pkg::t_bcd       w_count_inc;
    ctsf_pkg::t_byte      w_vis [4];
    ctsf_pkg::t_cnt       w_vis_n;
    ctsf_pkg::t_byte      w_exp [ctsf_pkg::BufDepth];
    ctsf_pkg::t_cnt       w_exp_n;
    logic                 n_blank_pend;
    ctsf_pkg::t_bcd       n_count;
    logic                 w_bcd_ok;

    assign w_take = o_out.valid && o_out.ready;
    assign w_load = r_in_valid &&
                    ((r_cnt == '0) || ((r_cnt == ctsf_pkg::t_cnt'(1)) && o_out.ready));

    assign i_in.ready        = !r_in_valid || w_load;
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = r_buf[0];
    assign o_out.last_of_run = (r_cnt == ctsf_pkg::t_cnt'(1));

    // number field: blanks for leading zeros, then a tab
    always_comb begin
        logic       lead;
        logic [3:0] v;
        lead = 1'b1;
        for (int d = ctsf_pkg::NumDigits - 1; d >= 0; d--) begin
            v = r_count[4*d +: 4];
            if (v != 4'd0 || d == 0) begin
                lead = 1'b0;
            end
            w_num[ctsf_pkg::NumDigits - 1 - d] =
                lead ? ctsf_pkg::ChSpace : (ctsf_pkg::ChZero + {4'd0, v});
        end
        w_num[ctsf_pkg::NumDigits] = ctsf_pkg::ChTab;
    end

    // BCD increment, sticks at all nines
    always_comb begin
        logic       all_nine;
        logic       carry;
        logic [3:0] v;
        all_nine    = 1'b1;
        carry       = 1'b1;
        w_count_inc = r_count;
        for (int d = 0; d < ctsf_pkg::NumDigits; d++) begin
            v = r_count[4*d +: 4];
            if (v != 4'd9) begin
                all_nine = 1'b0;
            end
            if (carry) begin
                if (v >= 4'd9) begin
                    w_count_inc[4*d +: 4] = 4'd0;
                end else begin
                    w_count_inc[4*d +: 4] = v + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine) begin
            w_count_inc = r_count;
        end
    end

    // caret and M- notation
    always_comb begin
        ctsf_pkg::t_byte low7;
        ctsf_pkg::t_byte cb0;
        ctsf_pkg::t_byte cb1;
        logic            two;
        low7 = {1'b0, r_in_byte[6:0]};
        cb1  = ctsf_pkg::ChQuest;
        two  = 1'b1;
        if (low7 == ctsf_pkg::ChDel) begin
            cb0 = ctsf_pkg::ChCaret;
        end else if (low7 < ctsf_pkg::CtrlLimit) begin
            cb0 = ctsf_pkg::ChCaret;
            cb1 = low7 + ctsf_pkg::CaretOffset;
        end else begin
            cb0 = low7;
            two = 1'b0;
        end
        if (r_in_byte[7]) begin
            w_vis[0] = ctsf_pkg::ChUpperM;
            w_vis[1] = ctsf_pkg::ChDash;
            w_vis[2] = cb0;
            w_vis[3] = cb1;
            w_vis_n  = two ? ctsf_pkg::t_cnt'(4) : ctsf_pkg::t_cnt'(3);
        end else begin
            w_vis[0] = cb0;
            w_vis[1] = cb1;
            w_vis[2] = ctsf_pkg::ChSpace;
            w_vis[3] = ctsf_pkg::ChSpace;
            w_vis_n  = two ? ctsf_pkg::t_cnt'(2) : ctsf_pkg::t_cnt'(1);
        end
    end

    // expansion of the staged byte
    always_comb begin
        logic is_lf;
        logic is_tab;
        logic numbered;
        is_lf    = (r_in_byte == ctsf_pkg::ChLf);
        is_tab   = (r_in_byte == ctsf_pkg::ChTab);
        numbered = 1'b0;
        for (int i = 0; i < ctsf_pkg::BufDepth; i++) begin
            w_exp[i] = r_in_byte;
        end
        w_exp_n      = ctsf_pkg::t_cnt'(1);
        n_blank_pend = r_blank_pend;

        unique case (r_mode)
            ctsf_pkg::VM_PLAIN: begin
                w_exp_n = ctsf_pkg::t_cnt'(1);
            end
            ctsf_pkg::VM_NUM_NONBLANK: begin
                numbered = r_line_start && !is_lf;
            end
            ctsf_pkg::VM_NUM_ALL: begin
                numbered = r_line_start;
            end
            ctsf_pkg::VM_SQUEEZE: begin
                if (r_line_start && is_lf) begin
                    n_blank_pend = 1'b1;
                    w_exp_n      = '0;
                end else if (r_line_start && r_blank_pend) begin
                    w_exp[0]     = ctsf_pkg::ChLf;
                    w_exp_n      = ctsf_pkg::t_cnt'(2);
                    n_blank_pend = 1'b0;
                end
            end
            ctsf_pkg::VM_ENDS: begin
                if (is_lf) begin
                    w_exp[0] = ctsf_pkg::ChDollar;
                    w_exp_n  = ctsf_pkg::t_cnt'(2);
                end
            end
            ctsf_pkg::VM_ENDS_VIS: begin
                if (is_lf) begin
                    w_exp[0] = ctsf_pkg::ChDollar;
                    w_exp_n  = ctsf_pkg::t_cnt'(2);
                end else if (!is_tab) begin
                    for (int i = 0; i < 4; i++) begin
                        w_exp[i] = w_vis[i];
                    end
                    w_exp_n = w_vis_n;
                end
            end
            ctsf_pkg::VM_TABS: begin
                if (is_tab) begin
                    w_exp[0] = ctsf_pkg::ChCaret;
                    w_exp[1] = ctsf_pkg::ChUpperI;
                    w_exp_n  = ctsf_pkg::t_cnt'(2);
                end
            end
            ctsf_pkg::VM_TABS_VIS: begin
                if (!is_lf) begin
                    for (int i = 0; i < 4; i++) begin
                        w_exp[i] = w_vis[i];
                    end
                    w_exp_n = w_vis_n;
                end
            end
        endcase

        if (numbered) begin
            for (int i = 0; i <= ctsf_pkg::NumDigits; i++) begin
                w_exp[i] = w_num[i];
            end
            w_exp_n = ctsf_pkg::t_cnt'(ctsf_pkg::NumDigits + 2);
            n_count = w_count_inc;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ctsf_pkg::VM_PLAIN;
            r_line_start <= 1'b1;
            r_blank_pend <= 1'b0;
            r_count      <= ctsf_pkg::BcdOne;
            r_in_valid   <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= ctsf_pkg::t_view_mode'(i_cfg_data);
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_load) begin
                r_line_start <= (r_in_byte == ctsf_pkg::ChLf);
                r_blank_pend <= n_blank_pend;
                r_count      <= n_count;
                r_cnt        <= w_exp_n;
            end else if (w_take) begin
                r_cnt <= r_cnt - ctsf_pkg::t_cnt'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
        if (w_load) begin
            r_buf <= w_exp;
        end else if (w_take) begin
            for (int i = 0; i < ctsf_pkg::BufDepth - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    always_comb begin
        w_bcd_ok = 1'b1;
        for (int d = 0; d < ctsf_pkg::NumDigits; d++) begin
            if (r_count[4*d +: 4] > 4'd9) begin
                w_bcd_ok = 1'b0;
            end
        end
    end

`include "cat_text_stream_formatter_core_assert.svh"

    `CTSF_ASSERT_ALWAYS(a_cnt_range, r_cnt <= ctsf_pkg::t_cnt'(ctsf_pkg::BufDepth), "buffer count exceeds depth")
    `CTSF_ASSERT_ALWAYS(a_bcd_digits, w_bcd_ok && (r_count != '0), "line counter is not valid BCD")
    `CTSF_ASSERT_NEXT(a_drain_step, w_take && (r_cnt > ctsf_pkg::t_cnt'(1)), r_cnt == $past(r_cnt) - ctsf_pkg::t_cnt'(1), "buffer did not drain by one word")
    `CTSF_ASSERT_NEXT(a_load_empty, r_in_valid && !i_in.ready, o_out.valid && $stable(r_in_byte), "staged byte lost while buffer busy")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned PipeSlack   = 16;   // cycles for a word still in flight
    localparam int unsigned PhaseWords  = 32;
    localparam int unsigned NumDirected = 23;

    typedef struct packed {
        ctsf_pkg::t_byte out_byte;
        logic            last_of_run;
    } t_fmt_word;

    typedef struct packed {
        ctsf_pkg::t_view_mode mode;
        ctsf_pkg::t_byte      data_byte;
    } t_dir_item;

    // Expected-output tracker: mirrors the formatter state and queues the words
    // each accepted input byte should produce.
    class format_ledger;
        ctsf_pkg::t_view_mode mode;
        bit                   at_line_start;
        bit                   blank_pending;
        logic [3:0]           line_digit[ctsf_pkg::NumDigits];   // index 0 = least significant
        t_fmt_word            expected[$];
        t_fmt_word            run[$];
        int unsigned          mismatches;

        function new();
            mode          = ctsf_pkg::VM_PLAIN;
            at_line_start = 1'b1;
            blank_pending = 1'b0;
            foreach (line_digit[d]) line_digit[d] = 4'd0;
            line_digit[0] = 4'd1;
            mismatches    = 0;
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        function void push(ctsf_pkg::t_byte b);
            t_fmt_word w;
            w.out_byte    = b;
            w.last_of_run = 1'b0;
            run.push_back(w);
        endfunction

        function void push_number();
            bit lead;
            lead = 1'b1;
            for (int d = ctsf_pkg::NumDigits - 1; d >= 0; d--) begin
                if (line_digit[d] != 4'd0 || d == 0) lead = 1'b0;
                push(lead ? ctsf_pkg::ChSpace
                          : ctsf_pkg::t_byte'(ctsf_pkg::ChZero + line_digit[d]));
            end
            push(ctsf_pkg::ChTab);
        endfunction

        function void bump_count();
            bit all_nine;
            all_nine = 1'b1;
            foreach (line_digit[d]) if (line_digit[d] != 4'd9) all_nine = 1'b0;
            if (all_nine) return;
            for (int d = 0; d < ctsf_pkg::NumDigits; d++) begin
                if (line_digit[d] == 4'd9) begin
                    line_digit[d] = 4'd0;
                end else begin
                    line_digit[d] = line_digit[d] + 4'd1;
                    return;
                end
            end
        endfunction

        function void push_visible(ctsf_pkg::t_byte c);
            if (c >= 8'd128) begin
                push(ctsf_pkg::ChUpperM);
                push(ctsf_pkg::ChDash);
                c = c - 8'd128;
            end
            if (c == ctsf_pkg::ChDel) begin
                push(ctsf_pkg::ChCaret);
                push(ctsf_pkg::ChQuest);
            end else if (c < ctsf_pkg::CtrlLimit) begin
                push(ctsf_pkg::ChCaret);
                push(c + ctsf_pkg::CaretOffset);
            end else begin
                push(c);
            end
        endfunction

        function void note_byte(ctsf_pkg::t_byte c);
            bit start;
            start = at_line_start;
            run.delete();
            case (mode)
                ctsf_pkg::VM_NUM_NONBLANK: begin
                    if (start && c != ctsf_pkg::ChLf) begin
                        push_number();
                        bump_count();
                    end
                    push(c);
                end
                ctsf_pkg::VM_NUM_ALL: begin
                    if (start) begin
                        push_number();
                        bump_count();
                    end
                    push(c);
                end
                ctsf_pkg::VM_SQUEEZE: begin
                    if (start && c == ctsf_pkg::ChLf) begin
                        blank_pending = 1'b1;
                    end else begin
                        if (start && blank_pending) begin
                            push(ctsf_pkg::ChLf);
                            blank_pending = 1'b0;
                        end
                        push(c);
                    end
                end
                ctsf_pkg::VM_ENDS: begin
                    if (c == ctsf_pkg::ChLf) push(ctsf_pkg::ChDollar);
                    push(c);
                end
                ctsf_pkg::VM_ENDS_VIS: begin
                    if (c == ctsf_pkg::ChLf) begin
                        push(ctsf_pkg::ChDollar);
                        push(ctsf_pkg::ChLf);
                    end else if (c == ctsf_pkg::ChTab) begin
                        push(ctsf_pkg::ChTab);
                    end else begin
                        push_visible(c);
                    end
                end
                ctsf_pkg::VM_TABS: begin
                    if (c == ctsf_pkg::ChTab) begin
                        push(ctsf_pkg::ChCaret);
                        push(ctsf_pkg::ChUpperI);
                    end else begin
                        push(c);
                    end
                end
                ctsf_pkg::VM_TABS_VIS: begin
                    if (c == ctsf_pkg::ChLf) push(ctsf_pkg::ChLf);
                    else push_visible(c);
                end
                default: push(c);
            endcase
            at_line_start = (c == ctsf_pkg::ChLf);
            if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[i]) expected.push_back(run[i]);
        endfunction

        function void check_word(ctsf_pkg::t_byte got_byte, logic got_last);
            t_fmt_word want;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected word %02h last %0b", got_byte, got_last);
                return;
            end
            want = expected.pop_front();
            if (want.out_byte !== got_byte || want.last_of_run !== got_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch: expected %02h last %0b, got %02h last %0b",
                             want.out_byte, want.last_of_run, got_byte, got_last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_data;

    ctsf_byte_if in_if ();
    ctsf_res_if  out_if ();

    cat_text_stream_formatter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    format_ledger ledger = new();
    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;

    localparam t_dir_item Directed[NumDirected] = '{
        '{ctsf_pkg::VM_ENDS_VIS, 8'hFF}, '{ctsf_pkg::VM_ENDS_VIS, ctsf_pkg::ChTab},
        '{ctsf_pkg::VM_ENDS_VIS, ctsf_pkg::ChLf}, '{ctsf_pkg::VM_ENDS_VIS, ctsf_pkg::ChDel},
        '{ctsf_pkg::VM_TABS_VIS, 8'h00}, '{ctsf_pkg::VM_TABS_VIS, 8'h80},
        '{ctsf_pkg::VM_TABS_VIS, 8'h1F}, '{ctsf_pkg::VM_TABS_VIS, ctsf_pkg::ChLf},
        '{ctsf_pkg::VM_SQUEEZE, ctsf_pkg::ChLf}, '{ctsf_pkg::VM_SQUEEZE, ctsf_pkg::ChLf},
        '{ctsf_pkg::VM_SQUEEZE, 8'h41},
        '{ctsf_pkg::VM_NUM_NONBLANK, ctsf_pkg::ChLf},
        '{ctsf_pkg::VM_NUM_NONBLANK, ctsf_pkg::ChLf},
        '{ctsf_pkg::VM_NUM_NONBLANK, 8'h42},
        '{ctsf_pkg::VM_NUM_ALL, ctsf_pkg::ChLf}, '{ctsf_pkg::VM_NUM_ALL, ctsf_pkg::ChLf},
        '{ctsf_pkg::VM_NUM_ALL, 8'hA0},
        '{ctsf_pkg::VM_ENDS, ctsf_pkg::ChLf}, '{ctsf_pkg::VM_ENDS, 8'h80},
        '{ctsf_pkg::VM_TABS, ctsf_pkg::ChTab}, '{ctsf_pkg::VM_TABS, ctsf_pkg::ChCaret},
        '{ctsf_pkg::VM_PLAIN, 8'hDF}, '{ctsf_pkg::VM_PLAIN, ctsf_pkg::ChLf}
    };

    localparam ctsf_pkg::t_view_mode PhaseMode[12] = '{
        ctsf_pkg::VM_TABS_VIS, ctsf_pkg::VM_SQUEEZE, ctsf_pkg::VM_NUM_NONBLANK,
        ctsf_pkg::VM_ENDS_VIS, ctsf_pkg::VM_PLAIN, ctsf_pkg::VM_NUM_ALL,
        ctsf_pkg::VM_TABS, ctsf_pkg::VM_ENDS, ctsf_pkg::VM_SQUEEZE,
        ctsf_pkg::VM_NUM_NONBLANK, ctsf_pkg::VM_TABS_VIS, ctsf_pkg::VM_PLAIN
    };

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_if.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            ledger.check_word(out_if.out_byte, out_if.last_of_run);
    end

    function automatic ctsf_pkg::t_byte text_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 28) return ctsf_pkg::ChLf;
        if (pick < 38) return ctsf_pkg::ChTab;
        if (pick < 75) return ctsf_pkg::t_byte'($urandom_range(32, 126));
        return ctsf_pkg::t_byte'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input ctsf_pkg::t_byte b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.data_byte = b;
        do @(posedge i_clk); while (!in_if.ready);
        ledger.note_byte(b);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (ledger.pending() != 0) @(negedge i_clk);
    endtask

    // mode change only with the pipe empty; a squeezed newline leaves no word
    // to wait on, so allow the pipe latency on top
    task automatic set_mode(input ctsf_pkg::t_view_mode m);
        wait_drained();
        repeat (PipeSlack) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        ledger.mode = m;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = 3'd0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        tx_idle_pct     = 31;
        rx_idle_pct     = 85;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // first bytes also check the reset mode before any write
        for (int k = 0; k < 3; k++) send_byte(text_byte());

        foreach (Directed[k]) begin
            if (ledger.mode != Directed[k].mode) set_mode(Directed[k].mode);
            send_byte(Directed[k].data_byte);
        end

        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: begin tx_idle_pct = 31; rx_idle_pct = 85; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 31; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            set_mode(PhaseMode[p]);
            for (int k = 0; k < PhaseWords; k++) begin
                if (k == PhaseWords / 2 && p % 2 == 1) wait_drained();
                send_byte(text_byte());
            end
        end

        wait_drained();
        repeat (PipeSlack) @(negedge i_clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
